[design/pcbp_pkg.sv]
// Shared types, codes and constants for the package container byte parser.
package pcbp_pkg;

  localparam int DEF_MAX_PATH_UNITS = 32768;

  localparam int CNT_W      = 17;
  localparam int UNITS_W    = 17;
  localparam int HDR_LEN    = 24;
  localparam int EXT_LEN    = 8;
  localparam int META_LEN   = 24;
  localparam int SIZE_LEN   = 8;
  localparam int HSIZE_V2   = 32;
  localparam int MIN_UNITS  = 4;

  localparam logic [7:0] CHR_R   = 8'h52;
  localparam logic [7:0] CHR_P   = 8'h50;
  localparam logic [7:0] CHR_K   = 8'h4B;
  localparam logic [7:0] CHR_G   = 8'h47;
  localparam logic [7:0] CHR_TWO = 8'h32;

  localparam logic [2:0] SEC_HDR    = 3'd0;
  localparam logic [2:0] SEC_EXT    = 3'd1;
  localparam logic [2:0] SEC_META   = 3'd2;
  localparam logic [2:0] SEC_PATH   = 3'd3;
  localparam logic [2:0] SEC_SIZE   = 3'd4;
  localparam logic [2:0] SEC_DATA   = 3'd5;
  localparam logic [2:0] SEC_REJECT = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_VER  = 3'd1;
  localparam logic [2:0] ST_BAD_HSZ  = 3'd2;
  localparam logic [2:0] ST_BAD_PATH = 3'd3;
  localparam logic [2:0] ST_BROKEN   = 3'd4;

  typedef enum logic [6:0] {
    PH_HDR    = 7'b0000001,
    PH_EXT    = 7'b0000010,
    PH_META   = 7'b0000100,
    PH_PATH   = 7'b0001000,
    PH_SIZE   = 7'b0010000,
    PH_DATA   = 7'b0100000,
    PH_BROKEN = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [2:0]  section;
    logic [7:0]  byte_value;
    logic        is_version_two;
    logic [15:0] path_units;
    logic [63:0] payload_remaining;
    logic        entry_end;
    logic [31:0] machine_id;
    logic [2:0]  status;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] m;
    unique case (pos)
      2'd0:    m = CHR_R;
      2'd1:    m = CHR_P;
      default: m = CHR_K;
    endcase
    return m;
  endfunction

endpackage

[design/pcbp_parse.sv]
// Parse state and the per-byte classification logic.
module pcbp_parse #(
  parameter int MAX_PATH_UNITS = pcbp_pkg::DEF_MAX_PATH_UNITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  output pcbp_pkg::result_t res
);
  import pcbp_pkg::*;

  phase_t               phase, phase_next;
  logic [CNT_W-1:0]     piece_count, piece_count_next;
  logic [CNT_W-1:0]     path_last, path_last_next;
  logic                 prefix_matches, prefix_matches_next;
  logic [7:0]           version_letter, version_letter_next;
  logic                 version_two, version_two_next;
  logic                 hsize_ok, hsize_ok_next;
  logic [31:0]          uid_word, uid_word_next;
  logic [UNITS_W-1:0]   units_acc, units_acc_next;
  logic                 path_high, path_high_next;
  logic [63:0]          payload_left, payload_left_next;
  logic [CNT_W:0]       two_units;
  logic                 len_ok;

  always_comb begin
    phase_next          = phase;
    piece_count_next    = piece_count + CNT_W'(1);
    path_last_next      = path_last;
    prefix_matches_next = prefix_matches;
    version_letter_next = version_letter;
    version_two_next    = version_two;
    hsize_ok_next       = hsize_ok;
    uid_word_next       = uid_word;
    units_acc_next      = units_acc;
    path_high_next      = path_high;
    payload_left_next   = payload_left;
    two_units           = '0;
    len_ok              = 1'b0;

    res                   = '0;
    res.byte_value        = data_byte;
    res.section           = SEC_REJECT;
    res.status            = ST_OK;

    unique case (phase)
      PH_HDR: begin
        res.section = SEC_HDR;
        if (piece_count < CNT_W'(3)) begin
          if (data_byte != magic_byte(piece_count[1:0])) prefix_matches_next = 1'b0;
        end else if (piece_count == CNT_W'(3)) begin
          version_letter_next = data_byte;
        end
        if (piece_count == CNT_W'(HDR_LEN - 1)) begin
          piece_count_next = '0;
          if (!prefix_matches || version_letter == CHR_G) begin
            version_two_next = 1'b0;
            phase_next       = PH_META;
          end else if (version_letter == CHR_TWO) begin
            version_two_next = 1'b1;
            phase_next       = PH_EXT;
          end else begin
            res.status = ST_BAD_VER;
            phase_next = PH_BROKEN;
          end
        end
      end

      PH_EXT: begin
        res.section = SEC_EXT;
        if (piece_count == CNT_W'(0)) begin
          hsize_ok_next = (data_byte == 8'(HSIZE_V2));
        end else if (piece_count < CNT_W'(4)) begin
          hsize_ok_next = hsize_ok && (data_byte == 8'd0);
        end else begin
          uid_word_next[8*(piece_count[1:0]) +: 8] = data_byte;
        end
        if (piece_count == CNT_W'(EXT_LEN - 1)) begin
          piece_count_next = '0;
          if (hsize_ok) begin
            phase_next = PH_META;
          end else begin
            res.status = ST_BAD_HSZ;
            phase_next = PH_BROKEN;
          end
        end
      end

      PH_META: begin
        res.section = SEC_META;
        // The path length sits in the last eight bytes; only 17 bits are kept,
        // any higher set bit just marks the length as too large.
        priority if (piece_count == CNT_W'(0)) begin
          units_acc_next = '0;
          path_high_next = 1'b0;
        end else if (piece_count == CNT_W'(16)) begin
          units_acc_next[7:0] = data_byte;
        end else if (piece_count == CNT_W'(17)) begin
          units_acc_next[15:8] = data_byte;
        end else if (piece_count == CNT_W'(18)) begin
          units_acc_next[16] = data_byte[0];
          path_high_next     = path_high || (data_byte[7:1] != 7'd0);
        end else if (piece_count > CNT_W'(18)) begin
          path_high_next = path_high || (data_byte != 8'd0);
        end else begin
          path_high_next = path_high;
        end
        two_units = {units_acc_next, 1'b0};
        len_ok    = !path_high_next && (units_acc_next >= UNITS_W'(MIN_UNITS))
                    && (units_acc_next <= UNITS_W'(MAX_PATH_UNITS));
        if (piece_count == CNT_W'(META_LEN - 1)) begin
          piece_count_next = '0;
          if (len_ok) begin
            res.path_units = units_acc_next[15:0];
            path_last_next = CNT_W'(two_units - (CNT_W+1)'(1));
            phase_next     = PH_PATH;
          end else begin
            res.status = ST_BAD_PATH;
            phase_next = PH_BROKEN;
          end
        end
      end

      PH_PATH: begin
        res.section    = SEC_PATH;
        res.path_units = units_acc[15:0];
        if (piece_count == path_last) begin
          piece_count_next = '0;
          phase_next       = PH_SIZE;
        end
      end

      PH_SIZE: begin
        res.section    = SEC_SIZE;
        res.path_units = units_acc[15:0];
        if (piece_count == CNT_W'(0)) payload_left_next = '0;
        payload_left_next[8*(piece_count[2:0]) +: 8] = data_byte;
        if (piece_count == CNT_W'(SIZE_LEN - 1)) begin
          piece_count_next      = '0;
          res.payload_remaining = payload_left_next;
          if (payload_left_next == 64'd0) begin
            res.entry_end = 1'b1;
            phase_next    = PH_META;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end

      PH_DATA: begin
        res.section           = SEC_DATA;
        res.path_units        = units_acc[15:0];
        payload_left_next     = payload_left - 64'd1;
        res.payload_remaining = payload_left_next;
        piece_count_next      = '0;
        if (payload_left == 64'd1) begin
          res.entry_end = 1'b1;
          phase_next    = PH_META;
        end
      end

      default: begin
        piece_count_next = '0;
        phase_next       = PH_BROKEN;
      end
    endcase

    res.is_version_two = version_two_next;
    res.machine_id     = uid_word_next;

    if (phase == PH_BROKEN) begin
      res.section        = SEC_REJECT;
      res.status         = ST_BROKEN;
      res.is_version_two = 1'b0;
      res.machine_id     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR;
      piece_count    <= '0;
      path_last      <= '0;
      prefix_matches <= 1'b1;
      version_letter <= '0;
      version_two    <= 1'b0;
      hsize_ok       <= 1'b0;
      uid_word       <= '0;
      units_acc      <= '0;
      path_high      <= 1'b0;
      payload_left   <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      piece_count    <= piece_count_next;
      path_last      <= path_last_next;
      prefix_matches <= prefix_matches_next;
      version_letter <= version_letter_next;
      version_two    <= version_two_next;
      hsize_ok       <= hsize_ok_next;
      uid_word       <= uid_word_next;
      units_acc      <= units_acc_next;
      path_high      <= path_high_next;
      payload_left   <= payload_left_next;
    end
  end

endmodule

[design/pcbp_result_reg.sv]
// Output register that holds one result item until the receiver takes it.
module pcbp_result_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  pcbp_pkg::result_t res,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              free,
  output pcbp_pkg::result_t held
);
  import pcbp_pkg::*;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

[design/package_container_byte_parser.sv]
// Package container byte parser: one byte in, one classified result out.
// An accepted byte is held in the input register, then parsed into the result
// register, where it waits until the receiver takes it.
// Throughput: one byte per cycle; the input register and the result register
// each hold one item, so input stalls only when both are full and the receiver stalls.
// Reset (synchronous, active high) empties both registers and returns the
// parser to the start of the fixed header.
module package_container_byte_parser #(
  parameter int MAX_PATH_UNITS = pcbp_pkg::DEF_MAX_PATH_UNITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  section,
  output logic [7:0]  byte_value,
  output logic        is_version_two,
  output logic [15:0] path_units,
  output logic [63:0] payload_remaining,
  output logic        entry_end,
  output logic [31:0] machine_id,
  output logic [2:0]  status
);
  import pcbp_pkg::*;

  logic    in_full;
  logic [7:0] in_byte;
  logic    out_free;
  logic    fire;
  result_t res;
  result_t held;

  assign fire     = in_full && out_free;
  assign in_stall = in_full && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= data_byte;
    end
  end

  pcbp_parse #(
    .MAX_PATH_UNITS(MAX_PATH_UNITS)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .data_byte(in_byte),
    .res      (res)
  );

  pcbp_result_reg u_result (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .res      (res),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .free     (out_free),
    .held     (held)
  );

  assign section           = held.section;
  assign byte_value        = held.byte_value;
  assign is_version_two    = held.is_version_two;
  assign path_units        = held.path_units;
  assign payload_remaining = held.payload_remaining;
  assign entry_end         = held.entry_end;
  assign machine_id        = held.machine_id;
  assign status            = held.status;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the package container byte parser.
module tb_top;
  import pcbp_pkg::*;

  localparam int          MAX_UNITS    = DEF_MAX_PATH_UNITS;
  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic [7:0]  val;
    logic [31:0] reps;
    bit          typed;
    logic [2:0]  sec;
    logic [2:0]  st;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  section;
  logic [7:0]  byte_value;
  logic        is_version_two;
  logic [15:0] path_units;
  logic [63:0] payload_remaining;
  logic        entry_end;
  logic [31:0] machine_id;
  logic [2:0]  status;

  logic        rx_stall = 1'b0;
  logic        hold_stall = 1'b0;
  assign out_stall = rx_stall | hold_stall;

  // Parser state as predicted from the byte stream alone.
  phase_t      ph = PH_HDR;
  int unsigned cnt = 0;
  int unsigned need = HDR_LEN;
  bit          prefix_ok = 1'b1;
  logic [7:0]  ver_letter = 8'h00;
  bit          v2 = 1'b0;
  logic [31:0] hdr_len = '0;
  logic [31:0] uid = '0;
  logic [63:0] plen = '0;
  logic [63:0] pay_left = '0;
  bit          broken = 1'b0;

  result_t     pending_results [$];
  int unsigned mismatches = 0;
  int unsigned fed_total = 0;
  int unsigned pressure_mark = 0;
  bit          random_on = 1'b0;
  bit          bulk = 1'b0;
  int unsigned tx_calm = 0;
  int unsigned rx_calm = 0;
  int unsigned cycle_count = 0;
  stim_row_t   plan [0:25];

  package_container_byte_parser #(.MAX_PATH_UNITS(MAX_UNITS)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .section(section),
    .byte_value(byte_value),
    .is_version_two(is_version_two),
    .path_units(path_units),
    .payload_remaining(payload_remaining),
    .entry_end(entry_end),
    .machine_id(machine_id),
    .status(status)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void start_meta();
    ph = PH_META;
    cnt = 0;
    need = META_LEN;
  endfunction

  function automatic void enter_broken();
    broken = 1'b1;
    ph = PH_BROKEN;
    cnt = 0;
  endfunction

  // Advances the predicted parser by one byte and returns the result it causes.
  function automatic result_t parse_byte(input logic [7:0] b);
    result_t     r;
    int unsigned pos;
    int unsigned two;
    int unsigned k;
    logic [63:0] units;
    r = '0;
    r.byte_value = b;
    units = '0;
    pos = cnt;
    if (broken) begin
      r.section = SEC_REJECT;
      r.status = ST_BROKEN;
      return r;
    end
    case (ph)
      PH_HDR: begin
        r.section = SEC_HDR;
        if (pos < 3) begin
          if (b != (pos == 0 ? CHR_R : pos == 1 ? CHR_P : CHR_K)) prefix_ok = 1'b0;
        end else if (pos == 3) begin
          ver_letter = b;
        end
        cnt = pos + 1;
        if (cnt >= HDR_LEN) begin
          cnt = 0;
          if (prefix_ok && ver_letter != CHR_G && ver_letter != CHR_TWO) begin
            r.status = ST_BAD_VER;
            enter_broken();
          end else begin
            v2 = prefix_ok && ver_letter == CHR_TWO;
            if (v2) begin
              ph = PH_EXT;
              need = EXT_LEN;
            end else begin
              hdr_len = HDR_LEN;
              start_meta();
            end
          end
        end
      end
      PH_EXT: begin
        r.section = SEC_EXT;
        if (pos < 4) hdr_len |= 32'(b) << (8 * pos);
        else if (pos < 8) uid |= 32'(b) << (8 * (pos - 4));
        cnt = pos + 1;
        if (cnt >= EXT_LEN) begin
          if (hdr_len != HSIZE_V2) begin
            r.status = ST_BAD_HSZ;
            enter_broken();
          end else begin
            start_meta();
          end
        end
      end
      PH_META: begin
        r.section = SEC_META;
        if (pos == 0) plen = '0;
        if (pos >= 16 && pos < 24) plen |= 64'(b) << (8 * (pos - 16));
        cnt = pos + 1;
        if (cnt >= META_LEN) begin
          cnt = 0;
          if (plen < MIN_UNITS || plen > MAX_UNITS) begin
            r.status = ST_BAD_PATH;
            enter_broken();
          end else begin
            ph = PH_PATH;
            need = plen[31:0] * 2 + SIZE_LEN;
            units = plen;
          end
        end
      end
      PH_PATH: begin
        // Path bytes and the payload size share one piece, split at twice the length.
        two = plen[31:0] * 2;
        units = plen;
        if (pos < two) begin
          r.section = SEC_PATH;
        end else begin
          k = pos - two;
          r.section = SEC_SIZE;
          if (k == 0) pay_left = '0;
          if (k < 8) pay_left |= 64'(b) << (8 * k);
        end
        cnt = pos + 1;
        if (cnt >= need) begin
          cnt = 0;
          r.payload_remaining = pay_left;
          if (pay_left == 0) begin
            r.entry_end = 1'b1;
            start_meta();
          end else begin
            ph = PH_DATA;
          end
        end
      end
      default: begin
        r.section = SEC_DATA;
        units = plen;
        pay_left = pay_left - 1;
        r.payload_remaining = pay_left;
        if (pay_left == 0) begin
          r.entry_end = 1'b1;
          start_meta();
        end
      end
    endcase
    r.is_version_two = v2;
    r.path_units = units[15:0];
    r.machine_id = uid;
    return r;
  endfunction

  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 60);
    return $urandom_range(0, 19);
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one item and waits for it to be taken; a typed section and status
  // replace the predicted ones where they can be read straight off the format.
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input logic [2:0] tsec = SEC_HDR, input logic [2:0] tst = ST_OK);
    int unsigned gap;
    result_t     want;
    gap = bulk ? 0 : draw_wait(tx_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = parse_byte(b);
    if (typed) begin
      want.section = tsec;
      want.status = tst;
    end
    pending_results.push_back(want);
    fed_total++;
  endtask

  task automatic send_le(input logic [63:0] v, input int unsigned n, input bit typed = 1'b0,
                         input logic [2:0] tsec = SEC_HDR, input logic [2:0] tst = ST_OK);
    for (int i = 0; i < n; i++) send_byte(v[8 * i +: 8], typed && i == n - 1, tsec, tst);
  endtask

  task automatic send_entry(input int unsigned units, input int unsigned pay);
    repeat (16) send_byte(any_byte());
    send_le(64'(units), SIZE_LEN);
    repeat (2 * units) send_byte(any_byte());
    send_le(64'(pay), SIZE_LEN);
    repeat (pay) send_byte(any_byte());
  endtask

  task automatic note_mismatch(input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch (expected/actual): sec %0d/%0d byte %h/%h v2 %0d/%0d units %0d/%0d",
               want.section, got.section, want.byte_value, got.byte_value,
               want.is_version_two, got.is_version_two, want.path_units, got.path_units,
               "  rem %0d/%0d end %0d/%0d uid %h/%h status %0d/%0d",
               want.payload_remaining, got.payload_remaining, want.entry_end, got.entry_end,
               want.machine_id, got.machine_id, want.status, got.status);
  endtask

  task automatic check_result();
    result_t got;
    result_t want;
    got.section = section;
    got.byte_value = byte_value;
    got.is_version_two = is_version_two;
    got.path_units = path_units;
    got.payload_remaining = payload_remaining;
    got.entry_end = entry_end;
    got.machine_id = machine_id;
    got.status = status;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Result arrived with no item outstanding: byte %h", byte_value);
      return;
    end
    want = pending_results.pop_front();
    if (got.section !== want.section || got.byte_value !== want.byte_value ||
        got.is_version_two !== want.is_version_two || got.path_units !== want.path_units ||
        got.payload_remaining !== want.payload_remaining ||
        got.entry_end !== want.entry_end || got.machine_id !== want.machine_id ||
        got.status !== want.status)
      note_mismatch(want, got);
  endtask

  initial begin : drain
    int unsigned w;
    wait (!rst);
    forever begin
      w = bulk ? 0 : draw_wait(rx_calm);
      if (w > 0) begin
        @(negedge clk);
        rx_stall <= 1'b1;
        repeat (w - 1) @(negedge clk);
      end
      @(negedge clk);
      rx_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      check_result();
    end
  end

  // A long hold-off on the result side while items keep being offered.
  initial begin : backpressure
    wait (random_on);
    wait (fed_total >= pressure_mark);
    @(negedge clk);
    hold_stall <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_stall <= 1'b0;
  end

  initial begin : stimulus
    int unsigned base;
    int unsigned units;
    int unsigned pay;
    logic [63:0] bad_len;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Version two header, extension, a shortest-path entry with no payload and
    // a 200-unit path entry with a single payload byte.
    plan = '{
      '{CHR_R,   1,     1'b1, SEC_HDR,  ST_OK},
      '{CHR_P,   1,     1'b0, SEC_HDR,  ST_OK},
      '{CHR_K,   1,     1'b0, SEC_HDR,  ST_OK},
      '{CHR_TWO, 1,     1'b0, SEC_HDR,  ST_OK},
      '{8'h00,   10,    1'b0, SEC_HDR,  ST_OK},
      '{8'hFF,   9,     1'b0, SEC_HDR,  ST_OK},
      '{8'h80,   1,     1'b1, SEC_HDR,  ST_OK},
      '{8'(HSIZE_V2), 1, 1'b1, SEC_EXT, ST_OK},
      '{8'h00,   3,     1'b0, SEC_EXT,  ST_OK},
      '{8'hA5,   1,     1'b0, SEC_EXT,  ST_OK},
      '{8'h5A,   1,     1'b0, SEC_EXT,  ST_OK},
      '{8'h01,   1,     1'b0, SEC_EXT,  ST_OK},
      '{8'hFE,   1,     1'b1, SEC_EXT,  ST_OK},
      '{8'h7F,   16,    1'b0, SEC_META, ST_OK},
      '{8'h04,   1,     1'b0, SEC_META, ST_OK},
      '{8'h00,   7,     1'b1, SEC_META, ST_OK},
      '{8'h2F,   8,     1'b1, SEC_PATH, ST_OK},
      '{8'h00,   8,     1'b1, SEC_SIZE, ST_OK},
      '{8'hC3,   16,    1'b0, SEC_META, ST_OK},
      '{8'hC8,   1,     1'b0, SEC_META, ST_OK},
      '{8'h00,   1,     1'b0, SEC_META, ST_OK},
      '{8'h00,   6,     1'b1, SEC_META, ST_OK},
      '{8'h55,   400,   1'b0, SEC_PATH, ST_OK},
      '{8'h01,   1,     1'b0, SEC_SIZE, ST_OK},
      '{8'h00,   7,     1'b1, SEC_SIZE, ST_OK},
      '{8'hAA,   1,     1'b1, SEC_DATA, ST_OK}
    };
    foreach (plan[i]) begin
      // The long path is streamed without idling to keep the run short.
      bulk = plan[i].reps > 100;
      repeat (plan[i].reps) send_byte(plan[i].val, plan[i].typed, plan[i].sec, plan[i].st);
    end
    bulk = 1'b0;

    base = fed_total;
    pressure_mark = base + 150;
    random_on = 1'b1;
    while (fed_total - base < RANDOM_ITEMS) begin
      units = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 200)
                                           : $urandom_range(MIN_UNITS, 12);
      pay = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
      send_entry(units, pay);
    end

    // A broken entry ends the stream; everything after it must be rejected.
    case ($urandom_range(0, 2))
      0: bad_len = 64'($urandom_range(0, MIN_UNITS - 1));
      1: bad_len = 64'(MAX_UNITS + 1);
      default: begin
        bad_len = {$urandom, $urandom};
        bad_len[63:56] = 8'($urandom_range(1, 255));
      end
    endcase
    repeat (16) send_byte(any_byte());
    send_le(bad_len, SIZE_LEN, 1'b1, SEC_META, ST_BAD_PATH);
    repeat (20) send_byte(any_byte(), 1'b1, SEC_REJECT, ST_BROKEN);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
